/* hw/rtl/sbtd_pkg.sv */
// ----------------------------------------------------------------------------
// SDRAM bus trace decoder package
// Shared widths, command and burst codes, and the item and result types.
// ----------------------------------------------------------------------------
package sbtd_pkg;

	// field widths
	localparam int CW_W     = 24;
	localparam int DATA_W   = 64;
	localparam int COUNT_W  = 64;
	localparam int ADDR_W   = 24;
	localparam int ROW_W    = 13;
	localparam int COL_W    = 8;
	localparam int BANK_W   = 2;
	localparam int BE_W     = 8;

	// read latency pipe and open row table
	localparam int READ_PIPE_DEPTH   = 7;
	localparam int LATE_SLOT         = READ_PIPE_DEPTH - 3;
	localparam int ROW_TABLE_ENTRIES = 8;
	localparam int ROW_IDX_W         = $clog2(ROW_TABLE_ENTRIES);

	// decoupling queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// raw command encodings on the bus
	localparam logic [2:0] RAW_MSR       = 3'd0;
	localparam logic [2:0] RAW_PRECHARGE = 3'd1;
	localparam logic [2:0] RAW_READ      = 3'd2;
	localparam logic [2:0] RAW_RESERVED  = 3'd3;
	localparam logic [2:0] RAW_WRITE     = 3'd4;
	localparam logic [2:0] RAW_BST       = 3'd5;
	localparam logic [2:0] RAW_ACTIVATE  = 3'd6;
	localparam logic [2:0] RAW_NOP       = 3'd7;

	// reported command codes
	typedef enum logic [2:0] {
		CMD_MSR        = 3'd0,
		CMD_PRECHARGE  = 3'd1,
		CMD_READ       = 3'd2,
		CMD_WRITE      = 3'd3,
		CMD_BURST_STOP = 3'd4,
		CMD_ACTIVATE   = 3'd5,
		CMD_NOP        = 3'd6,
		CMD_UNKNOWN    = 3'd7
	} cmd_code_t;

	// burst state
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2
	} mode_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic                  stopped;
		cmd_code_t             code;
		logic                  sel;
		logic                  cs0;
		logic                  unk0;
		logic                  all_banks;
		logic [BANK_W-1:0]     bank;
		logic [ROW_W-1:0]      row;
		logic [DATA_W-1:0]     data;
		logic [BE_W-1:0]       byte_en;
	} sbtd_item_t;

	// one result item
	typedef struct packed {
		logic                  stopped;
		cmd_code_t             command_code;
		logic                  read_valid;
		logic [ADDR_W-1:0]     read_address;
		logic [DATA_W-1:0]     read_data;
		logic                  write_valid;
		logic [ADDR_W-1:0]     write_address;
		logic [DATA_W-1:0]     write_data;
		logic [BE_W-1:0]       write_byte_enable;
	} sbtd_result_t;

	// bus command to reported code
	function automatic cmd_code_t decode_cmd(input logic [2:0] raw);
		cmd_code_t c;
		unique case (raw)
			RAW_MSR:       c = CMD_MSR;
			RAW_PRECHARGE: c = CMD_PRECHARGE;
			RAW_READ:      c = CMD_READ;
			RAW_RESERVED:  c = CMD_UNKNOWN;
			RAW_WRITE:     c = CMD_WRITE;
			RAW_BST:       c = CMD_BURST_STOP;
			RAW_ACTIVATE:  c = CMD_ACTIVATE;
			RAW_NOP:       c = CMD_NOP;
			default:       c = CMD_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/sbtd_if.sv */
// ----------------------------------------------------------------------------
// SDRAM bus trace decoder channels
// Valid/ready channels for bus samples in and decoded results out.
// ----------------------------------------------------------------------------
interface sbtd_in_if import sbtd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CW_W-1:0]   control_word;
	logic [DATA_W-1:0] data_word;

	modport source (output valid, output control_word, output data_word, input ready);
	modport sink (input valid, input control_word, input data_word, output ready);
endinterface

interface sbtd_out_if import sbtd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              stopped;
	logic [2:0]        command_code;
	logic              read_valid;
	logic [ADDR_W-1:0] read_address;
	logic [DATA_W-1:0] read_data;
	logic              write_valid;
	logic [ADDR_W-1:0] write_address;
	logic [DATA_W-1:0] write_data;
	logic [BE_W-1:0]   write_byte_enable;

	modport source (
		output valid, output stopped, output command_code,
		output read_valid, output read_address, output read_data,
		output write_valid, output write_address, output write_data,
		output write_byte_enable, input ready
	);
	modport sink (
		input valid, input stopped, input command_code,
		input read_valid, input read_address, input read_data,
		input write_valid, input write_address, input write_data,
		input write_byte_enable, output ready
	);
endinterface

/* hw/rtl/sdram_bus_trace_decoder_top.sv */
// SDRAM bus trace decoder: takes one captured bus sample per cycle while the
// queue has room and gives one result item per sample. The sustained rate is
// one item per cycle while the output side is ready, set by the back end,
// which updates the burst, open-row table and latency pipe per item. A
// two-entry queue separates the decoding front end from the back end, so
// output stalls do not stop input acceptance until the queue is full. The
// user must write the stop index only while the block is idle; the block
// itself does not enforce this. Once the sample count reaches the stop
// index, items are returned flagged as stopped with all other fields zero.
// ----------------------------------------------------------------------------
// SDRAM bus trace decoder top level
// Front end, item queue and back end wired to the sample and result channels.
// ----------------------------------------------------------------------------
module sdram_bus_trace_decoder_top import sbtd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	sbtd_in_if.sink            in_ch,
	sbtd_out_if.source         out_ch
);

	logic       push;
	logic       space;
	logic       pop;
	logic       avail;
	sbtd_item_t push_item;
	sbtd_item_t head;

	// decode and classify
	sbtd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.space       (space),
		.push        (push),
		.item        (push_item)
	);

	// decoupling queue
	sbtd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.space     (space),
		.pop       (pop),
		.avail     (avail),
		.head      (head)
	);

	// bus state tracking and results
	sbtd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.item   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

/* hw/rtl/sbtd_front.sv */
// ----------------------------------------------------------------------------
// SDRAM bus trace decoder front end
// Accepts samples, checks the stop index, decodes the control word and
// reorders the data bytes into a classified item for the queue.
// ----------------------------------------------------------------------------
module sbtd_front import sbtd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	sbtd_in_if.sink            in_ch,
	input  logic               space,
	output logic               push,
	output sbtd_item_t         item
);

	logic [COUNT_W-1:0] stop_index_q;
	logic [COUNT_W-1:0] sample_count_q;
	logic [CW_W-1:0]    cw;
	logic [DATA_W-1:0]  dw;
	logic [BE_W-1:0]    mask;
	logic               stopped;

	assign cw = in_ch.control_word;
	assign dw = in_ch.data_word;

	// handshake: take an item whenever the queue has room
	assign in_ch.ready = space;
	assign push        = in_ch.valid & space;

	// decoding stops once the sample count reaches the stop index
	assign stopped = (sample_count_q >= stop_index_q);

	// byte mask sits in addr bits 2..9
	assign mask = cw[18:11];

	// classify the sample
	always_comb begin
		item           = '0;
		item.stopped   = stopped;
		item.code      = decode_cmd(cw[4:2]);
		item.cs0       = cw[0];
		item.sel       = ~(cw[0] & cw[1]);
		item.unk0      = cw[5];
		item.all_banks = cw[19];
		item.bank      = cw[23:22];
		item.row       = cw[21:9];
		item.data      = {dw[DATA_W-17:0], dw[DATA_W-1:DATA_W-16]};
		item.byte_en   = ~{mask[BE_W-3:0], mask[BE_W-1:BE_W-2]};
	end

	// stop index register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_index_q <= '1;
		end else if (cfg_wr_en) begin
			stop_index_q <= cfg_wr_data;
		end
	end

	// sample counter advances on every accepted item that is not stopped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
		end else if (push && !stopped) begin
			sample_count_q <= sample_count_q + COUNT_W'(1);
		end
	end

endmodule

/* hw/rtl/sbtd_fifo.sv */
// ----------------------------------------------------------------------------
// SDRAM bus trace decoder item queue
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module sbtd_fifo import sbtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sbtd_item_t push_item,
	output logic       space,
	input  logic       pop,
	output logic       avail,
	output sbtd_item_t head
);

	sbtd_item_t            mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign space = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign avail = (count_q != '0);
	assign head  = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/sbtd_back.sv */
// ----------------------------------------------------------------------------
// SDRAM bus trace decoder back end
// Tracks open rows, the current burst, the read latency pipe and the write
// slot; builds one result per item into an output register.
// ----------------------------------------------------------------------------
module sbtd_back import sbtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       avail,
	input  sbtd_item_t item,
	output logic       pop,
	sbtd_out_if.source out_ch
);

	// burst and table state
	mode_t                 mode_q, mode_n;
	logic [COL_W-1:0]      col_q, col_n;
	logic [BANK_W-1:0]     bank_q, bank_n;
	logic [ROW_W-1:0]      row_q, row_n;
	logic                  select_q, select_n;
	logic [ROW_W-1:0]      open_row_q [ROW_TABLE_ENTRIES];
	logic [ROW_W-1:0]      open_row_n [ROW_TABLE_ENTRIES];
	logic [ROW_IDX_W-1:0]  tidx;

	// read latency pipe and write slot
	logic [READ_PIPE_DEPTH-1:0] rp_valid_q, rp_valid_n;
	logic [ADDR_W-1:0]          rp_addr_q [READ_PIPE_DEPTH];
	logic [ADDR_W-1:0]          rp_addr_n [READ_PIPE_DEPTH];
	logic                       ws_valid_q, ws_valid_n;
	logic [ADDR_W-1:0]          ws_addr_q, ws_addr_n;
	logic [ADDR_W-1:0]          beat_addr;

	// output register
	sbtd_result_t res;
	sbtd_result_t out_q;
	logic         out_valid_q;
	logic         update;

	// take the next item when the output register is free or draining
	assign pop    = avail & (~out_valid_q | out_ch.ready);
	assign update = pop & ~item.stopped;
	assign tidx   = ROW_IDX_W'({item.cs0, item.bank});

	// next state of burst, table, pipe and write slot
	always_comb begin
		mode_n     = mode_q;
		col_n      = col_q;
		bank_n     = bank_q;
		row_n      = row_q;
		select_n   = select_q;
		open_row_n = open_row_q;
		rp_valid_n = rp_valid_q;
		rp_addr_n  = rp_addr_q;
		ws_valid_n = ws_valid_q;
		ws_addr_n  = ws_addr_q;
		beat_addr  = '0;
		if (update) begin
			// advance the latency pipe
			for (int i = READ_PIPE_DEPTH - 1; i >= 1; i--) begin
				rp_valid_n[i] = rp_valid_q[i-1];
				rp_addr_n[i]  = rp_addr_q[i-1];
			end
			rp_valid_n[0] = 1'b0;
			ws_valid_n    = 1'b0;

			// command effects on a selected bus
			if (item.sel) begin
				unique case (item.code)
					CMD_READ, CMD_WRITE: begin
						mode_n   = (item.code == CMD_WRITE) ? MODE_WRITE : MODE_READ;
						col_n    = item.row[COL_W-1:0];
						bank_n   = item.bank;
						row_n    = open_row_q[tidx];
						select_n = item.cs0;
					end
					CMD_BURST_STOP: begin
						mode_n = MODE_IDLE;
					end
					CMD_PRECHARGE: begin
						if (item.all_banks || item.bank == bank_q) begin
							mode_n = MODE_IDLE;
						end
						// flush early slots when unk0 is clear and no burst remains
						if (!item.unk0 && mode_n == MODE_IDLE) begin
							for (int i = 0; i <= LATE_SLOT; i++) begin
								rp_valid_n[i] = 1'b0;
							end
						end
					end
					CMD_ACTIVATE: begin
						open_row_n[tidx] = item.row;
					end
					default: begin
					end
				endcase
			end

			// burst beat
			beat_addr = {select_n, row_n, bank_n, col_n};
			unique case (mode_n)
				MODE_READ: begin
					if (item.unk0) begin
						rp_valid_n[LATE_SLOT] = 1'b1;
						rp_addr_n[LATE_SLOT]  = beat_addr;
					end else begin
						rp_valid_n[0] = 1'b1;
						rp_addr_n[0]  = beat_addr;
					end
					col_n = col_n + COL_W'(1);
				end
				MODE_WRITE: begin
					ws_valid_n = 1'b1;
					ws_addr_n  = beat_addr;
					col_n      = col_n + COL_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// result for the current item
	always_comb begin
		res = '0;
		if (item.stopped) begin
			res.stopped = 1'b1;
		end else begin
			res.command_code = item.code;
			if (rp_valid_q[READ_PIPE_DEPTH-1]) begin
				res.read_valid   = 1'b1;
				res.read_address = rp_addr_q[READ_PIPE_DEPTH-1];
				res.read_data    = item.data;
			end
			if (ws_valid_q) begin
				res.write_valid       = 1'b1;
				res.write_address     = ws_addr_q;
				res.write_data        = item.data;
				res.write_byte_enable = item.byte_en;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			col_q       <= '0;
			bank_q      <= '0;
			row_q       <= '0;
			select_q    <= 1'b0;
			open_row_q  <= '{default: '0};
			rp_valid_q  <= '0;
			ws_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q      <= mode_n;
			col_q       <= col_n;
			bank_q      <= bank_n;
			row_q       <= row_n;
			select_q    <= select_n;
			open_row_q  <= open_row_n;
			rp_valid_q  <= rp_valid_n;
			ws_valid_q  <= ws_valid_n;
			out_valid_q <= pop | (out_valid_q & ~out_ch.ready);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rp_addr_q <= rp_addr_n;
		ws_addr_q <= ws_addr_n;
		if (pop) begin
			out_q <= res;
		end
	end

	// output channel
	assign out_ch.valid             = out_valid_q;
	assign out_ch.stopped           = out_q.stopped;
	assign out_ch.command_code      = out_q.command_code;
	assign out_ch.read_valid        = out_q.read_valid;
	assign out_ch.read_address      = out_q.read_address;
	assign out_ch.read_data         = out_q.read_data;
	assign out_ch.write_valid       = out_q.write_valid;
	assign out_ch.write_address     = out_q.write_address;
	assign out_ch.write_data        = out_q.write_data;
	assign out_ch.write_byte_enable = out_q.write_byte_enable;

endmodule
